@@ rtl/core/rdsm_pkg.sv @@
// rdsm_pkg: shared types and codes for the dot-star pattern matcher
// used by rdsm_cell and regex_dot_star_matcher_unit; no dependencies
`timescale 1ns / 1ps

package rdsm_pkg;

   // item kinds carried on req_tuser
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_BEGIN  = 2'd2;
   localparam logic [1:0] KIND_TEXT   = 2'd3;

   localparam int SYMBOL_WIDTH = 8;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic                    restart;   // rebuild active set from position 0
      logic                    take;      // advance active set by one text byte
      logic [SYMBOL_WIDTH-1:0] symbol;    // text byte or element byte
      logic                    any_char;  // element being appended is a dot
      logic                    repeat_req; // element being appended is starred
   } cell_ctl_type;

endpackage

@@ rtl/core/rdsm_cell.sv @@
// rdsm_cell: one pattern element plus the active bit of the position after it
// depends on rdsm_pkg for the broadcast control struct
`timescale 1ns / 1ps

module rdsm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rdsm_pkg::cell_ctl_type ctl,
   input  logic                  wr_en,        // store the element in this cell
   input  logic                  old_prev,     // active bit of previous position, before update
   input  logic                  closed_prev,  // active bit of previous position, after update
   output logic                  old_out,      // this cell's active bit, before update
   output logic                  closed_out    // this cell's active bit, after update
);

   logic [rdsm_pkg::SYMBOL_WIDTH-1:0] char_ff;
   logic                              any_ff;
   logic                              star_ff;
   logic                              act_ff;
   logic                              act_in;
   logic                              eff_star;
   logic                              hit;
   logic                              step;

   // star flag as seen this cycle: a write in flight takes effect at once
   assign eff_star = wr_en ? ctl.repeat_req : star_ff;
   assign hit      = any_ff || (char_ff == ctl.symbol);
   // consume one byte: starred loops in place, plain advances from the left
   assign step     = hit && (star_ff ? act_ff : old_prev);

   // next active bit with the empty-step ripple from the left neighbor
   always_comb begin
      if (ctl.restart) begin
         act_in = eff_star && closed_prev;
      end else if (ctl.take) begin
         act_in = step || (star_ff && closed_prev);
      end else begin
         act_in = act_ff;
      end
   end

   assign old_out    = act_ff;
   assign closed_out = act_in;

   // active bit
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

   // element store, written on append only
   always_ff @(posedge clock) begin
      if (wr_en) begin
         char_ff <= ctl.symbol;
         any_ff  <= ctl.any_char;
         star_ff <= ctl.repeat_req;
      end
   end

endmodule

@@ rtl/core/regex_dot_star_matcher_unit.sv @@
// regex_dot_star_matcher_unit: whole-text matcher for literal, dot and star patterns
// depends on rdsm_pkg and rdsm_cell (one cell per pattern element)
`timescale 1ns / 1ps
//
//  channel  | direction | tdata (low bit up)                          | tuser
//  ---------+-----------+---------------------------------------------+-----------
//  req_     | in        | symbol[7:0], any_char[8], repeat_req[9], 0s  | kind[1:0]
//  rsp_     | out       | matched[0], overflow[1], pattern_length[7:2] | none
//
//  one transaction per cycle while rsp_tready is high; result valid the next cycle
//  active-set update and empty-step ripple through the cell row are combinational
//  the result register lets a new transaction enter while the last result is being taken
//  rsp_tready low holds the result and stalls req_ only while the register is full
//  synchronous reset: empty pattern, only position 0 active, no result pending

module regex_dot_star_matcher_unit #(
   parameter int MAX_ELEMENTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // symbol[7:0], any_char[8], repeat_req[9], zero pad
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // matched[0], overflow[1], pattern_length[7:2]
);

   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   logic                  accept;
   logic [1:0]            kind;
   logic                  full;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  pos0_ff;
   logic                  pos0_in;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_data_ff;
   logic [7:0]            rsp_data_in;
   logic                  overflow;
   logic                  matched;
   logic [CW+5:0]         count_wide;
   logic [MAX_ELEMENTS:0] old_pos;
   logic [MAX_ELEMENTS:0] closed_pos;
   rdsm_pkg::cell_ctl_type ctl;

   // handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign kind       = req_tuser;
   assign full       = (count_ff == CW'(MAX_ELEMENTS));
   assign overflow   = (kind == rdsm_pkg::KIND_APPEND) && full;

   // control broadcast to the cell row
   always_comb begin
      ctl.symbol     = req_tdata[7:0];
      ctl.any_char   = req_tdata[8];
      ctl.repeat_req = req_tdata[9];
      ctl.restart    = 1'b0;
      ctl.take       = 1'b0;
      if (accept) begin
         case (kind)
            rdsm_pkg::KIND_CLEAR:  ctl.restart = 1'b1;
            rdsm_pkg::KIND_APPEND: ctl.restart = !full;
            rdsm_pkg::KIND_BEGIN:  ctl.restart = 1'b1;
            rdsm_pkg::KIND_TEXT:   ctl.take    = 1'b1;
            default:               ctl.restart = 1'b0;
         endcase
      end
   end

   // element count
   always_comb begin
      count_in = count_ff;
      if (accept && kind == rdsm_pkg::KIND_CLEAR) begin
         count_in = '0;
      end else if (accept && kind == rdsm_pkg::KIND_APPEND && !full) begin
         count_in = count_ff + CW'(1);
      end
   end

   // start position
   always_comb begin
      if (ctl.restart) begin
         pos0_in = 1'b1;
      end else if (ctl.take) begin
         pos0_in = 1'b0;
      end else begin
         pos0_in = pos0_ff;
      end
   end

   assign old_pos[0]    = pos0_ff;
   assign closed_pos[0] = pos0_in;

   // row of cells, one per pattern element
   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      logic wr_en;
      assign wr_en = accept && (kind == rdsm_pkg::KIND_APPEND) && (count_ff == CW'(i));
      rdsm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .wr_en       (wr_en),
         .old_prev    (old_pos[i]),
         .closed_prev (closed_pos[i]),
         .old_out     (old_pos[i+1]),
         .closed_out  (closed_pos[i+1])
      );
   end

   // result: active bit at the end of the pattern
   assign matched     = closed_pos[count_in];
   assign count_wide  = {6'd0, count_in};
   assign rsp_data_in = {count_wide[5:0], overflow, matched};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos0_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pos0_ff  <= pos0_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ELEMENTS))
      else $error("element count beyond store depth");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      accept && kind == rdsm_pkg::KIND_CLEAR |=> count_ff == '0)
      else $error("clear did not empty the pattern");

   a_text_leaves_start : assert property (@(posedge clock) disable iff (reset)
      accept && kind == rdsm_pkg::KIND_TEXT |=> !pos0_ff)
      else $error("start position still active after a text byte");

   a_overflow_only_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1] |-> full)
      else $error("overflow reported with room in the store");

   a_restart_sets_start : assert property (@(posedge clock) disable iff (reset)
      ctl.restart |=> pos0_ff)
      else $error("restart did not activate the start position");

endmodule

@@ tb/tb_regex_dot_star_matcher_unit.sv @@
// tb_regex_dot_star_matcher_unit: self-checking testbench for the dot-star pattern matcher
// predicts every response from its own model of the pattern store and active-position set
// depends on rdsm_pkg and regex_dot_star_matcher_unit
`timescale 1ns / 1ps

module tb_regex_dot_star_matcher_unit;

   localparam int MAX_ELEMENTS = 32;
   localparam int DIRECTED_ITEMS = 23;
   localparam int RANDOM_ITEMS = 1850;

   typedef struct packed {
      logic [5:0] pattern_length;
      logic       overflow;
      logic       matched;
   } match_result_type;

   // scoreboard: predicts the matcher and checks responses in order
   class match_scoreboard;
      logic [7:0]    elem_char [MAX_ELEMENTS];
      bit            elem_any [MAX_ELEMENTS];
      bit            elem_star [MAX_ELEMENTS];
      int unsigned   elem_count;
      bit [MAX_ELEMENTS:0] live_pos;
      match_result_type expected_results [$];
      int            errors;

      function new();
         elem_count = 0;
         live_pos = '0;
         live_pos[0] = 1'b1;
         errors = 0;
      endfunction

      // empty steps through starred elements, rising position order
      function void ripple_stars();
         for (int i = 0; i < elem_count; i++)
            if (elem_star[i] && live_pos[i]) live_pos[i+1] = 1'b1;
      endfunction

      function void restart_from_start();
         live_pos = '0;
         live_pos[0] = 1'b1;
         ripple_stars();
      endfunction

      function void advance_on_byte(logic [7:0] c);
         bit [MAX_ELEMENTS:0] nxt;
         bit hit;
         nxt = '0;
         for (int i = 0; i < elem_count; i++) begin
            hit = elem_any[i] || (elem_char[i] == c);
            if (hit && elem_star[i] && live_pos[i+1]) nxt[i+1] = 1'b1;
            if (hit && !elem_star[i] && live_pos[i]) nxt[i+1] = 1'b1;
         end
         live_pos = nxt;
         ripple_stars();
      endfunction

      function void note_request(logic [1:0] kind, logic [7:0] sym, logic any, logic star);
         match_result_type res;
         res = '0;
         case (kind)
            rdsm_pkg::KIND_CLEAR: begin
               elem_count = 0;
               restart_from_start();
            end
            rdsm_pkg::KIND_APPEND: begin
               if (elem_count >= MAX_ELEMENTS) begin
                  res.overflow = 1'b1;
               end else begin
                  elem_char[elem_count] = sym;
                  elem_any[elem_count] = any;
                  elem_star[elem_count] = star;
                  elem_count++;
                  restart_from_start();
               end
            end
            rdsm_pkg::KIND_BEGIN: restart_from_start();
            default: advance_on_byte(sym);
         endcase
         res.matched = live_pos[elem_count];
         res.pattern_length = elem_count[5:0];
         expected_results = {expected_results, res};
      endfunction

      function void check_response(logic [7:0] tdata);
         match_result_type got, want;
         got = tdata;
         if (expected_results.size() == 0) begin
            $error("unexpected response transaction: tdata %h", tdata);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got.matched !== want.matched) begin
               $error("matched: expected %0d, actual %0d", want.matched, got.matched);
               errors++;
            end
            if (got.overflow !== want.overflow) begin
               $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
               errors++;
            end
            if (got.pattern_length !== want.pattern_length) begin
               $error("pattern_length: expected %0d, actual %0d",
                      want.pattern_length, got.pattern_length);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = rdsm_pkg::KIND_CLEAR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   match_scoreboard sb = new();

   // stimulus-side copy of the loaded pattern, used to build matching texts
   logic [7:0] pat_char [MAX_ELEMENTS];
   bit         pat_any [MAX_ELEMENTS];
   bit         pat_star [MAX_ELEMENTS];
   int         pat_len = 0;

   int  items_sent = 0;
   int  burst_left = 0;
   bit  hold_request = 1'b0;
   bit  hold_done = 1'b0;

   regex_dot_star_matcher_unit #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watch both channels; values seen here are the ones before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[7:0], req_tdata[8], req_tdata[9]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata);
      end
   end

   // offer one transaction, with bursts and idle gaps between them
   task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
                            input logic any, input logic star);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(30, 80))
                                                  : int'($urandom_range(1, 8));
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, star, any, sym};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // stop offering until every predicted response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_symbol();
      case ($urandom_range(0, 9))
         0, 1, 2: return "a";
         3, 4:    return "b";
         5:       return "*";
         6:       return ".";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic append_element(input logic [7:0] sym, input bit any, input bit star);
      send_item(rdsm_pkg::KIND_APPEND, sym, any, star);
      if (pat_len < MAX_ELEMENTS) begin
         pat_char[pat_len] = sym;
         pat_any[pat_len] = any;
         pat_star[pat_len] = star;
         pat_len++;
      end
   endtask

   // text that follows the pattern, with occasional corruption
   task automatic send_text();
      int reps;
      logic [7:0] c;
      if ($urandom_range(0, 5) != 0)
         send_item(rdsm_pkg::KIND_BEGIN, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (int i = 0; i < pat_len; i++) begin
         reps = pat_star[i] ? int'($urandom_range(0, 3)) : 1;
         for (int r = 0; r < reps; r++) begin
            c = pat_any[i] ? pick_symbol() : pat_char[i];
            if ($urandom_range(0, 19) == 0) c = pick_symbol();
            send_item(rdsm_pkg::KIND_TEXT, c, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end
      end
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3))
            send_item(rdsm_pkg::KIND_TEXT, pick_symbol(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
   endtask

   // receiver: ready in stretches of its own pattern, plus one long hold-off
   initial begin
      int mode;
      int span;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (64) @(posedge clock);
         end else begin
            mode = int'($urandom_range(0, 3));
            span = int'($urandom_range(1, 40));
            repeat (span) begin
               case (mode)
                  0, 1:    rsp_tready <= 1'b1;
                  2:       rsp_tready <= 1'($urandom_range(0, 1));
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // main sequence: reset, directed cases, random episodes, end check
   initial begin
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // text before any begin, on an empty pattern, then an empty match
      send_item(rdsm_pkg::KIND_TEXT, "a", 1'b0, 1'b0);
      send_item(rdsm_pkg::KIND_BEGIN, 8'h00, 1'b0, 1'b0);
      // literal a, literal dot byte, starred dot, starred literal asterisk
      append_element("a", 1'b0, 1'b0);
      append_element(".", 1'b0, 1'b0);
      append_element(8'hFF, 1'b1, 1'b1);
      append_element("*", 1'b0, 1'b1);
      send_item(rdsm_pkg::KIND_TEXT, "a", 1'b0, 1'b0);
      send_item(rdsm_pkg::KIND_TEXT, ".", 1'b1, 1'b1);
      send_item(rdsm_pkg::KIND_TEXT, 8'h00, 1'b0, 1'b0);
      send_item(rdsm_pkg::KIND_TEXT, "*", 1'b0, 1'b0);
      send_item(rdsm_pkg::KIND_TEXT, "*", 1'b0, 1'b0);
      send_item(rdsm_pkg::KIND_BEGIN, 8'h00, 1'b0, 1'b0);
      send_item(rdsm_pkg::KIND_TEXT, "a", 1'b0, 1'b0);
      send_item(rdsm_pkg::KIND_TEXT, "b", 1'b0, 1'b0);
      // clear with junk in the unused fields, then text on an empty pattern
      send_item(rdsm_pkg::KIND_CLEAR, 8'hFF, 1'b1, 1'b1);
      pat_len = 0;
      send_item(rdsm_pkg::KIND_TEXT, 8'hFF, 1'b1, 1'b1);
      // lone starred element matches empty text
      append_element(8'h00, 1'b0, 1'b1);
      send_item(rdsm_pkg::KIND_BEGIN, 8'h00, 1'b0, 1'b0);
      send_item(rdsm_pkg::KIND_TEXT, 8'h00, 1'b0, 1'b0);
      send_item(rdsm_pkg::KIND_TEXT, 8'h01, 1'b0, 1'b0);
      send_item(rdsm_pkg::KIND_BEGIN, 8'hAA, 1'b1, 1'b1);
      append_element(8'hFF, 1'b0, 1'b0);
      send_item(rdsm_pkg::KIND_TEXT, 8'hFF, 1'b0, 1'b0);
      drain();

      // long receiver hold-off while the sender keeps offering
      hold_request = 1'b1;
      burst_left = 200;

      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: any kind with any content
            repeat ($urandom_range(1, 4))
               send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            pat_len = 0;
            send_item(rdsm_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            send_item(rdsm_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            pat_len = 0;
            // mostly short patterns, now and then a full store with extra appends
            n = ($urandom_range(0, 11) == 0) ? MAX_ELEMENTS + int'($urandom_range(1, 3))
                                              : int'($urandom_range(0, 6));
            for (int i = 0; i < n; i++)
               append_element(pick_symbol(), ($urandom_range(0, 3) == 0),
                              ($urandom_range(0, 2) == 0));
            repeat ($urandom_range(1, 4)) send_text();
         end
         if ($urandom_range(0, 39) == 0) drain();
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected responses never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
